/* sv/radix2_dit_fft_core_defines.svh */
// Assertion macros shared by the FFT core checker.
`ifndef RADIX2_DIT_FFT_CORE_DEFINES_SVH
`define RADIX2_DIT_FFT_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define R2F_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define R2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/r2fft_pkg.sv */
// Package with constants, command types and the twiddle table of the FFT core.
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;
	localparam int MAX_LOG   = 10;
	localparam int NPTS      = 1 << MAX_LOG;
	localparam int ADDR_W    = MAX_LOG;
	localparam int CNT_W     = MAX_LOG + 1;
	localparam int STAGE_W   = 4;
	localparam int SAMPLE_W  = 16;
	localparam int WORD_W    = 27;
	localparam int TW_W      = 16;
	localparam int TW_F      = TW_W - 1;
	localparam int TW_DEPTH  = NPTS / 2;
	localparam int TW_IDX_W  = MAX_LOG - 1;
	localparam int PROD_W    = TW_W + WORD_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int LOG_W     = 4;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(MAX_LOG);
	localparam logic [SUM_W-1:0] TW_HALF = SUM_W'(1) << (TW_F - 1);
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;
	localparam logic REG_LOG_POINTS = 1'b0;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef struct packed {
		logic                ld_we;
		logic [ADDR_W-1:0]   ld_addr;
		logic                bin_cap;
		logic [ADDR_W-1:0]   bin_addr;
		logic                bin_last;
		logic                out_load;
		logic                bfly;
		logic                mul_en;
		logic                rnd_en;
		logic                wr_e;
		logic                wr_o;
		logic [ADDR_W-1:0]   e_addr;
		logic [ADDR_W-1:0]   o_addr;
		logic [TW_IDX_W-1:0] tw_idx;
	} cmd_t;

	typedef logic [2*TW_W-1:0] tw_rom_t [TW_DEPTH];

	function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] r;
		for (int k = 0; k < ADDR_W; k++) begin
			r[k] = v[ADDR_W-1-k];
		end
		return r;
	endfunction

	function automatic longint sin_q30(input longint unsigned num, input bit wide_den);
		longint unsigned x, x2, t;
		longint sum;
		if (wide_den) begin
			x = (PI_Q30 * num + (64'd1 << MAX_LOG)) >> (MAX_LOG + 1);
		end else begin
			x = (PI_Q30 * num + (64'd1 << (MAX_LOG - 1))) >> MAX_LOG;
		end
		x2 = (x * x) >> 30;
		t = x;
		sum = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			t = (t * x2) >> 30;
			case (k)
				1: t = t / 64'd6;
				2: t = t / 64'd20;
				3: t = t / 64'd42;
				4: t = t / 64'd72;
				5: t = t / 64'd110;
				6: t = t / 64'd156;
				7: t = t / 64'd210;
				8: t = t / 64'd272;
				9: t = t / 64'd342;
				10: t = t / 64'd420;
				11: t = t / 64'd506;
				default: t = t / 64'd600;
			endcase
			if (k % 2 == 1) sum = sum - longint'(t);
			else sum = sum + longint'(t);
		end
		if (sum < 0) sum = 0;
		if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
		return sum;
	endfunction

	function automatic logic [TW_W-1:0] q30_to_tw(input longint s);
		longint a, r;
		a = (s < 0) ? -s : s;
		r = (a + (64'sd1 <<< (29 - TW_F))) >>> (30 - TW_F);
		if (s < 0) return TW_W'(-r);
		if (r > (64'sd1 <<< TW_F) - 1) r = (64'sd1 <<< TW_F) - 1;
		return TW_W'(r);
	endfunction

	function automatic tw_rom_t build_rom();
		tw_rom_t rom;
		longint c, s;
		longint unsigned n, i;
		n = longint'(NPTS);
		for (int k = 0; k < TW_DEPTH; k++) begin
			i = longint'(k);
			if (4 * i <= n) c = sin_q30(n - 4 * i, 1'b1);
			else c = -sin_q30(4 * i - n, 1'b1);
			if (4 * i <= n) s = sin_q30(2 * i, 1'b0);
			else s = sin_q30(n - 2 * i, 1'b0);
			rom[k] = {q30_to_tw(c), q30_to_tw(-s)};
		end
		return rom;
	endfunction

	localparam tw_rom_t TW_ROM = build_rom();
endpackage
`default_nettype wire

/* sv/r2fft_ctrl.sv */
// Controller of the FFT core: load and read counters, butterfly sequencer, output handshake.
`timescale 1ns / 1ps
`default_nettype none
module r2fft_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	input  wire logic [r2fft_pkg::LOG_W-1:0] log_points,
	output r2fft_pkg::cmd_t                  cmd
);
	import r2fft_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RDOUT = 7'b0000010,
		ST_BRD   = 7'b0000100,
		ST_BMUL  = 7'b0001000,
		ST_BRND  = 7'b0010000,
		ST_BWRE  = 7'b0100000,
		ST_BWRO  = 7'b1000000
	} state_t;

	state_t              state_q, state_nx;
	logic [CNT_W-1:0]    load_cnt_q, load_cnt_nx;
	logic [ADDR_W-1:0]   read_cnt_q, read_cnt_nx;
	logic                done_q, done_nx;
	logic                out_valid_q, out_valid_nx;
	logic [STAGE_W-1:0]  stage_q, stage_nx;
	logic [TW_IDX_W-1:0] bf_q, bf_nx;
	logic [LOG_W-1:0]    lg;
	logic [CNT_W-1:0]    npts;
	logic [ADDR_W-1:0]   pmask;
	logic [CNT_W-1:0]    cnt, cnt_inc;
	logic [ADDR_W-1:0]   idx;
	logic                idx_last;
	logic [ADDR_W-1:0]   hmask, bz, e_addr;
	logic [ADDR_W-1:0]   tw_full;
	logic                bf_last;
	logic                acc;

	always_comb begin
		if (log_points == '0) lg = LOG_W'(1);
		else if (log_points > LOG_W'(MAX_LOG)) lg = LOG_W'(MAX_LOG);
		else lg = log_points;
	end

	assign npts     = CNT_W'(1) << lg;
	assign pmask    = ADDR_W'(npts - CNT_W'(1));
	assign cnt      = done_q ? '0 : load_cnt_q;
	assign cnt_inc  = cnt + CNT_W'(1);
	assign idx      = read_cnt_q & pmask;
	assign idx_last = (idx == pmask);

	assign hmask   = (ADDR_W'(1) << (stage_q - STAGE_W'(1))) - ADDR_W'(1);
	assign bz      = ADDR_W'(bf_q);
	assign e_addr  = ((bz & ~hmask) << 1) | (bz & hmask);
	assign tw_full = (bz & hmask) << (STAGE_W'(MAX_LOG) - stage_q);
	assign bf_last = ({2'b00, bf_q} == (npts >> 1) - CNT_W'(1));

	assign in_ready  = (state_q == ST_IDLE) && (func == FUNC_LOAD || !out_valid_q);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.ld_addr  = bit_rev(cnt[ADDR_W-1:0] & pmask) >> (LOG_W'(MAX_LOG) - lg);
		cmd.bin_addr = idx;
		cmd.bin_last = idx_last;
		cmd.e_addr   = e_addr;
		cmd.o_addr   = e_addr | (hmask + ADDR_W'(1));
		cmd.tw_idx   = tw_full[TW_IDX_W-1:0];
		state_nx     = state_q;
		load_cnt_nx  = load_cnt_q;
		read_cnt_nx  = read_cnt_q;
		done_nx      = done_q;
		stage_nx     = stage_q;
		bf_nx        = bf_q;
		out_valid_nx = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				if (acc && func == FUNC_LOAD) begin
					cmd.ld_we = 1'b1;
					done_nx   = 1'b0;
					if (cnt_inc >= npts) begin
						load_cnt_nx = '0;
						read_cnt_nx = '0;
						stage_nx    = STAGE_W'(1);
						bf_nx       = '0;
						state_nx    = ST_BRD;
					end else begin
						load_cnt_nx = cnt_inc;
						if (done_q) read_cnt_nx = '0;
					end
				end else if (acc && done_q) begin
					cmd.bin_cap = 1'b1;
					read_cnt_nx = idx_last ? '0 : idx + ADDR_W'(1);
					state_nx    = ST_RDOUT;
				end
			end
			ST_RDOUT: begin
				cmd.out_load = 1'b1;
				out_valid_nx = 1'b1;
				state_nx     = ST_IDLE;
			end
			ST_BRD: begin
				cmd.bfly = 1'b1;
				state_nx = ST_BMUL;
			end
			ST_BMUL: begin
				cmd.bfly   = 1'b1;
				cmd.mul_en = 1'b1;
				state_nx   = ST_BRND;
			end
			ST_BRND: begin
				cmd.bfly   = 1'b1;
				cmd.rnd_en = 1'b1;
				state_nx   = ST_BWRE;
			end
			ST_BWRE: begin
				cmd.bfly = 1'b1;
				cmd.wr_e = 1'b1;
				state_nx = ST_BWRO;
			end
			ST_BWRO: begin
				cmd.bfly = 1'b1;
				cmd.wr_o = 1'b1;
				if (!bf_last) begin
					bf_nx    = bf_q + TW_IDX_W'(1);
					state_nx = ST_BRD;
				end else if (stage_q != lg) begin
					bf_nx    = '0;
					stage_nx = stage_q + STAGE_W'(1);
					state_nx = ST_BRD;
				end else begin
					done_nx  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_cnt_q  <= '0;
			read_cnt_q  <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			stage_q     <= STAGE_W'(1);
			bf_q        <= '0;
		end else begin
			state_q     <= state_nx;
			load_cnt_q  <= load_cnt_nx;
			read_cnt_q  <= read_cnt_nx;
			done_q      <= done_nx;
			out_valid_q <= out_valid_nx;
			stage_q     <= stage_nx;
			bf_q        <= bf_nx;
		end
	end
endmodule
`default_nettype wire

/* sv/r2fft_dp.sv */
// Datapath of the FFT core: sample memory, twiddle table, butterfly arithmetic, output register.
`timescale 1ns / 1ps
`default_nettype none
module r2fft_dp (
	input  wire logic                                  clk,
	input  wire r2fft_pkg::cmd_t                       cmd,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
	output logic [r2fft_pkg::ADDR_W-1:0]               bin_index,
	output logic signed [r2fft_pkg::WORD_W-1:0]        bin_re,
	output logic signed [r2fft_pkg::WORD_W-1:0]        bin_im,
	output logic                                       last_bin
);
	import r2fft_pkg::*;

	logic [2*WORD_W-1:0]        mem_q [NPTS];
	logic [2*WORD_W-1:0]        rd_a_q, rd_b_q, wdata;
	logic [ADDR_W-1:0]          ra, wa;
	logic                       we;
	logic [2*TW_W-1:0]          tw_q;
	logic signed [TW_W-1:0]     w_re, w_im;
	logic signed [WORD_W-1:0]   x_re, x_im;
	logic signed [PROD_W-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [WORD_W-1:0]   e_re_q, e_im_q, z_re_q, z_im_q;
	logic signed [SUM_W-1:0]    s_re, s_im;
	logic [ADDR_W-1:0]          idx_hold_q;
	logic                       last_hold_q;

	assign ra   = cmd.bfly ? cmd.e_addr : cmd.bin_addr;
	assign w_re = tw_q[2*TW_W-1:TW_W];
	assign w_im = tw_q[TW_W-1:0];
	assign x_re = rd_b_q[2*WORD_W-1:WORD_W];
	assign x_im = rd_b_q[WORD_W-1:0];

	assign s_re = SUM_W'(p_rr_q) - SUM_W'(p_ii_q) + TW_HALF;
	assign s_im = SUM_W'(p_ri_q) + SUM_W'(p_ir_q) + TW_HALF;

	always_comb begin
		we    = cmd.ld_we || cmd.wr_e || cmd.wr_o;
		wa    = cmd.o_addr;
		wdata = {e_re_q - z_re_q, e_im_q - z_im_q};
		if (cmd.ld_we) begin
			wa    = cmd.ld_addr;
			wdata = {{(WORD_W-SAMPLE_W){sample_re[SAMPLE_W-1]}}, sample_re,
				{(WORD_W-SAMPLE_W){sample_im[SAMPLE_W-1]}}, sample_im};
		end else if (cmd.wr_e) begin
			wa    = cmd.e_addr;
			wdata = {e_re_q + z_re_q, e_im_q + z_im_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wdata;
		end
		rd_a_q <= mem_q[ra];
		rd_b_q <= mem_q[cmd.o_addr];
	end

	always_ff @(posedge clk) begin
		tw_q <= TW_ROM[cmd.tw_idx];
		if (cmd.mul_en) begin
			p_rr_q <= w_re * x_re;
			p_ii_q <= w_im * x_im;
			p_ri_q <= w_re * x_im;
			p_ir_q <= w_im * x_re;
			e_re_q <= rd_a_q[2*WORD_W-1:WORD_W];
			e_im_q <= rd_a_q[WORD_W-1:0];
		end
		if (cmd.rnd_en) begin
			z_re_q <= WORD_W'(s_re >>> TW_F);
			z_im_q <= WORD_W'(s_im >>> TW_F);
		end
		if (cmd.bin_cap) begin
			idx_hold_q  <= cmd.bin_addr;
			last_hold_q <= cmd.bin_last;
		end
		if (cmd.out_load) begin
			bin_index <= idx_hold_q;
			last_bin  <= last_hold_q;
			bin_re    <= rd_a_q[2*WORD_W-1:WORD_W];
			bin_im    <= rd_a_q[WORD_W-1:0];
		end
	end
endmodule
`default_nettype wire

/* sv/radix2_dit_fft_core.sv */
// Top level of the radix-2 decimation-in-time FFT core with its configuration register.
`timescale 1ns / 1ps
`default_nettype none
// In-place radix-2 FFT of up to 1024 complex 16-bit samples, with 27-bit unscaled results.
// A load beat writes the sample to its bit-reversed address. After the last sample of a
// frame the core is busy while one butterfly at a time passes through read, multiply,
// round and two writes on the single write port of the sample memory. A read beat reads
// the sample memory and then loads its bin into an output register, where it is held;
// loads are still taken while it waits.
module radix2_dit_fft_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  func,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [r2fft_pkg::ADDR_W-1:0]               bin_index,
	output logic signed [r2fft_pkg::WORD_W-1:0]        bin_re,
	output logic signed [r2fft_pkg::WORD_W-1:0]        bin_im,
	output logic                                       last_bin,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [r2fft_pkg::APB_AW-1:0]          paddr,
	input  wire logic [r2fft_pkg::APB_DW-1:0]          pwdata,
	output logic [r2fft_pkg::APB_DW-1:0]               prdata,
	output logic                                       pready
);
	import r2fft_pkg::*;

	logic [LOG_W-1:0] log_points_q;
	logic             reg_sel;
	cmd_t             cmd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1] == REG_LOG_POINTS);
	assign prdata  = reg_sel ? APB_DW'(log_points_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_points_q <= LOG_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			log_points_q <= pwdata[LOG_W-1:0];
		end
	end

	r2fft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.log_points (log_points_q),
		.cmd        (cmd)
	);

	r2fft_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.bin_index (bin_index),
		.bin_re    (bin_re),
		.bin_im    (bin_im),
		.last_bin  (last_bin)
	);
endmodule
`default_nettype wire

/* sv/r2fft_checker.sv */
// Port-level checker of the FFT core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "radix2_dit_fft_core_defines.svh"
module r2fft_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  func,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic [r2fft_pkg::ADDR_W-1:0]          bin_index,
	input wire logic signed [r2fft_pkg::WORD_W-1:0]   bin_re
);
	import r2fft_pkg::*;

	`R2F_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(bin_re) && $stable(bin_index), "Output beat changed while stalled.")
	`R2F_ASSERT_SAME(a_out_from_read, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready && func == FUNC_READ, 2), "Result beat without a read beat.")
	`R2F_ASSERT_SAME(a_no_read_while_full, clk, arst_n, out_valid && !out_ready, !(in_ready && func == FUNC_READ), "Read taken while a result waits.")
endmodule

bind radix2_dit_fft_core r2fft_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.bin_index (bin_index),
	.bin_re    (bin_re)
);
`default_nettype wire

/* tb/radix2_dit_fft_core_checker.sv */
// Checker that predicts the FFT core's bins and compares them with the output channel.
`timescale 1ns / 1ps
module radix2_dit_fft_core_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic                                  in_ready,
	input  wire logic                                  func,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
	input  wire logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_ready,
	input  wire logic [r2fft_pkg::ADDR_W-1:0]          bin_index,
	input  wire logic signed [r2fft_pkg::WORD_W-1:0]   bin_re,
	input  wire logic signed [r2fft_pkg::WORD_W-1:0]   bin_im,
	input  wire logic                                  last_bin,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [r2fft_pkg::APB_AW-1:0]          paddr,
	input  wire logic [r2fft_pkg::APB_DW-1:0]          pwdata,
	input  wire logic                                  pready,
	output int                                         fails,
	output int                                         pending
);
	import r2fft_pkg::*;

	localparam logic [APB_AW-1:0] LOG_ADDR = APB_AW'(REG_LOG_POINTS) << 2;
	localparam longint unsigned PI_FIXED = 64'd3373259426;

	typedef struct {
		logic [ADDR_W-1:0]        idx;
		logic signed [WORD_W-1:0] re;
		logic signed [WORD_W-1:0] im;
		logic                     last;
	} bin_t;

	logic signed [WORD_W-1:0] mem_re [NPTS];
	logic signed [WORD_W-1:0] mem_im [NPTS];
	longint cos_q [TW_DEPTH];
	longint sin_q [TW_DEPTH];
	bin_t   bins_due [$];
	int     loaded;
	int     read_pos;
	bit     spectrum_ready;
	logic [LOG_W-1:0] log_reg;

	function automatic longint sine_fixed(longint unsigned num, longint unsigned den);
		longint unsigned x, x2, term;
		longint acc;
		x = (PI_FIXED * num + den / 2) / den;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			acc = (k % 2) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
		return acc;
	endfunction

	function automatic longint to_q15(longint v);
		longint mag, r;
		mag = (v < 0) ? -v : v;
		r = (mag + (64'sd1 <<< 14)) >>> 15;
		if (v < 0) return -r;
		return (r > 32767) ? 32767 : r;
	endfunction

	function automatic int eff_log();
		if (log_reg < 1) return 1;
		if (log_reg > MAX_LOG) return MAX_LOG;
		return int'(log_reg);
	endfunction

	function automatic int flip_bits(int v, int bits);
		int r;
		r = 0;
		for (int k = 0; k < bits; k++) r = (r << 1) | ((v >> k) & 1);
		return r;
	endfunction

	task automatic run_fft(int lg);
		int n, h, e, o, t;
		longint xr, xi, zr, zi, er, ei;
		n = 1 << lg;
		for (int s = 1; s <= lg; s++) begin
			h = 1 << (s - 1);
			for (int i = 0; i < n; i += 2 * h) begin
				for (int j = 0; j < h; j++) begin
					e = i + j;
					o = e + h;
					t = j << (MAX_LOG - s);
					xr = mem_re[o];
					xi = mem_im[o];
					er = mem_re[e];
					ei = mem_im[e];
					zr = (cos_q[t] * xr - sin_q[t] * xi + 16384) >>> 15;
					zi = (cos_q[t] * xi + sin_q[t] * xr + 16384) >>> 15;
					mem_re[o] = WORD_W'(er - zr);
					mem_im[o] = WORD_W'(ei - zi);
					mem_re[e] = WORD_W'(er + zr);
					mem_im[e] = WORD_W'(ei + zi);
				end
			end
		end
	endtask

	initial begin
		longint n, c, s;
		n = NPTS;
		for (longint i = 0; i < TW_DEPTH; i++) begin
			c = (4 * i <= n) ? sine_fixed(n - 4 * i, 2 * n) : -sine_fixed(4 * i - n, 2 * n);
			s = (4 * i <= n) ? sine_fixed(2 * i, n) : sine_fixed(n - 2 * i, n);
			cos_q[i] = to_q15(c);
			sin_q[i] = to_q15(-s);
		end
		fails = 0;
		pending = 0;
		loaded = 0;
		read_pos = 0;
		spectrum_ready = 0;
		log_reg = LOG_RESET;
	end

	always @(posedge clk) begin
		bin_t b;
		int lg, n, a;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (bins_due.size() == 0) begin
					$error("unexpected bin beat, bin_index %0d", bin_index);
					fails++;
				end else begin
					b = bins_due.pop_front();
					if (bin_index !== b.idx) begin
						$error("bin_index: expected %0d, got %0d", b.idx, bin_index);
						fails++;
					end
					if (bin_re !== b.re) begin
						$error("bin_re: expected %0d, got %0d", b.re, bin_re);
						fails++;
					end
					if (bin_im !== b.im) begin
						$error("bin_im: expected %0d, got %0d", b.im, bin_im);
						fails++;
					end
					if (last_bin !== b.last) begin
						$error("last_bin: expected %0d, got %0d", b.last, last_bin);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				lg = eff_log();
				n = 1 << lg;
				if (func == FUNC_LOAD) begin
					if (spectrum_ready) begin
						spectrum_ready = 0;
						loaded = 0;
						read_pos = 0;
					end
					a = flip_bits(loaded & (n - 1), lg);
					mem_re[a] = WORD_W'(sample_re);
					mem_im[a] = WORD_W'(sample_im);
					loaded = (loaded + 1) & 'h7FF;
					if (loaded >= n) begin
						run_fft(lg);
						spectrum_ready = 1;
						loaded = 0;
						read_pos = 0;
					end
				end else if (spectrum_ready) begin
					a = read_pos & (n - 1);
					b.idx = ADDR_W'(a);
					b.re = mem_re[a];
					b.im = mem_im[a];
					b.last = (a == n - 1);
					bins_due = {bins_due, b};
					read_pos = (a == n - 1) ? 0 : a + 1;
				end
			end
			if (psel && penable && pwrite && pready && paddr == LOG_ADDR)
				log_reg = pwdata[LOG_W-1:0];
			pending = bins_due.size();
		end
	end
endmodule

/* tb/tb_top.sv */
// Testbench top for the FFT core: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
	import r2fft_pkg::*;

	localparam int ITEM_GOAL = 1850;
	localparam int IDLE_LIMIT = 200000;
	localparam logic [APB_AW-1:0] LOG_ADDR = APB_AW'(REG_LOG_POINTS) << 2;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic func = FUNC_LOAD;
	logic signed [SAMPLE_W-1:0] sample_re = '0;
	logic signed [SAMPLE_W-1:0] sample_im = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [ADDR_W-1:0] bin_index;
	logic signed [WORD_W-1:0] bin_re;
	logic signed [WORD_W-1:0] bin_im;
	logic last_bin;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	int fails;
	int pending;
	int items = 0;
	int quiet = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;
	bit rx_hold_req = 0;

	always #6 clk = ~clk;

	radix2_dit_fft_core u_dut (.*);

	radix2_dit_fft_core_checker u_chk (.*);

	task automatic send(logic f, logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		sample_re <= re;
		sample_im <= im;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items++;
	endtask

	task automatic finish_beats();
		in_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic drain();
		finish_beats();
		wait (pending == 0 && in_ready);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_log(logic [APB_DW-1:0] v);
		drain();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= LOG_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic frame(int n, int reads, bit noise);
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 7) == 0) send(FUNC_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			send(FUNC_LOAD, pick_sample(), pick_sample());
		end
		for (int i = 0; i < reads; i++) send(FUNC_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
	endtask

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("radix2_dit_fft_core: mismatch");
			$finish;
		end
	end

	initial begin
		int gap;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req && !held) begin
				out_ready <= 0;
				repeat (500) @(posedge clk);
				held = 1;
			end
			gap = rx_burst ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	initial begin
		int lg, n, frames, reads;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_log(1);
		send(FUNC_READ, 16'sh7FFF, 16'sh8000);
		send(FUNC_LOAD, 16'sh7FFF, 16'sh8000);
		send(FUNC_LOAD, 16'sh8000, 16'sh7FFF);
		repeat (3) send(FUNC_READ, '0, '0);
		write_log(2);
		send(FUNC_LOAD, 16'sh7FFF, 16'sh7FFF);
		send(FUNC_LOAD, 16'sh8000, 16'sh8000);
		send(FUNC_LOAD, 16'sh0000, -16'sd1);
		send(FUNC_LOAD, 16'sh0001, 16'sh0000);
		repeat (4) send(FUNC_READ, '0, '0);
		send(FUNC_LOAD, 16'sh7FFF, 16'sh0000);
		write_log(0);
		send(FUNC_LOAD, 16'sh8000, 16'sh8000);
		send(FUNC_LOAD, 16'sh8000, 16'sh8000);
		repeat (2) send(FUNC_READ, '0, '0);
		send(FUNC_LOAD, 16'sh0000, 16'sh7FFF);

		write_log(15);
		tx_burst = 1;
		frame(NPTS, 0, 0);
		rx_hold_req = 1;
		for (int i = 0; i < 40; i++) send(FUNC_READ, '0, '0);
		tx_burst = 0;

		while (items < ITEM_GOAL) begin
			lg = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
			write_log(lg);
			n = 1 << ((lg < 1) ? 1 : lg);
			frames = $urandom_range(1, 4);
			for (int f = 0; f < frames && items < ITEM_GOAL; f++) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
				reads = ($urandom_range(0, 9) == 0) ? 0 : n + $urandom_range(0, n / 2);
				frame(n, reads, 1);
			end
		end
		tx_burst = 0;
		rx_burst = 0;

		drain();
		repeat (100) @(posedge clk);
		if (fails == 0) $display("radix2_dit_fft_core: match");
		else $display("radix2_dit_fft_core: mismatch");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+sv
sv/r2fft_pkg.sv
sv/r2fft_ctrl.sv
sv/r2fft_dp.sv
sv/radix2_dit_fft_core.sv
sv/r2fft_checker.sv
tb/radix2_dit_fft_core_checker.sv
tb/tb_top.sv
